### rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants of the character reference decoder
// Command and status words between controller and datapath, the named
// reference table and the ASCII codes the parser looks for.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int NAME_TBL_SIZE = 32;
    localparam int NAME_TBL_CHARS = 6;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // names left-justified, first letter in the top byte
    localparam logic [47:0] NAME_TXT [NAME_TBL_SIZE] = '{
        {"amp", 24'd0}, {"lt", 32'd0}, {"gt", 32'd0}, {"quot", 16'd0},
        {"apos", 16'd0}, {"nbsp", 16'd0}, {"copy", 16'd0}, {"reg", 24'd0},
        {"trade", 8'd0}, {"mdash", 8'd0}, {"ndash", 8'd0}, {"ldquo", 8'd0},
        {"rdquo", 8'd0}, {"lsquo", 8'd0}, {"rsquo", 8'd0}, "hellip",
        "middot", {"euro", 16'd0}, {"pound", 8'd0}, {"yen", 24'd0},
        {"cent", 16'd0}, {"laquo", 8'd0}, {"raquo", 8'd0}, {"times", 8'd0},
        "divide", {"deg", 24'd0}, "plusmn", "frac12",
        "frac14", "frac34", {"sup2", 16'd0}, {"sup3", 16'd0}
    };

    localparam logic [2:0] NAME_LEN [NAME_TBL_SIZE] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6,
        3'd6, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5,
        3'd6, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd4
    };

    localparam logic [31:0] NAME_CP [NAME_TBL_SIZE] = '{
        32'd38, 32'd60, 32'd62, 32'd34, 32'd39, 32'd160, 32'd169, 32'd174,
        32'd8482, 32'd8212, 32'd8211, 32'd8220, 32'd8221, 32'd8216, 32'd8217,
        32'd8230, 32'd183, 32'd8364, 32'd163, 32'd165, 32'd162, 32'd171,
        32'd187, 32'd215, 32'd247, 32'd176, 32'd177, 32'd189, 32'd188,
        32'd190, 32'd178, 32'd179
    };

    typedef enum logic [1:0] {
        CP_HOLD = 2'd0,
        CP_DEC  = 2'd1,
        CP_HEX  = 2'd2
    } t_cp_op;

    typedef enum logic [1:0] {
        ECP_NONE  = 2'd0,
        ECP_ACC   = 2'd1,
        ECP_TABLE = 2'd2
    } t_ecp_src;

    typedef enum logic [1:0] {
        OSEL_IN   = 2'd0,
        OSEL_HELD = 2'd1,
        OSEL_UTF8 = 2'd2,
        OSEL_RAW  = 2'd3
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        t_cp_op   cp_op;
        logic     clear_ref;
        logic     name_push;
        t_ecp_src ecp_load;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_final;
    } t_dp_cmd;

    typedef struct packed {
        logic in_alpha;
        logic in_digit;
        logic in_hex;
        logic in_amp;
        logic in_hash;
        logic in_x;
        logic in_semi;
        logic held_amp;
        logic held_last;
        logic len_full;
        logic tbl_hit;
        logic utf8_end;
        logic raw_at_len;
        logic raw_past_len;
        logic slot_free;
    } t_dp_stat;

endpackage

### rtl/hed_if.sv
// ----------------------------------------------------------------------------
// hed_in_if / hed_out_if: valid/ready channels of the decoder
// Input carries raw text bytes, output carries decoded UTF-8 bytes.
// ----------------------------------------------------------------------------
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

### rtl/hed_dp.sv
// ----------------------------------------------------------------------------
// hed_dp: decoder datapath
// Code point accumulator, name buffer, table lookup, UTF-8 byte builder
// and the output register.
// ----------------------------------------------------------------------------
module hed_dp
    import hed_pkg::*;
#(
    parameter int NAME_MAX_LEN = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_out_ready,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    localparam int LW = $clog2(NAME_MAX_LEN + 1);
    localparam int IW = $clog2(NAME_MAX_LEN);
    localparam int CW = $clog2(NAME_MAX_LEN + 2);

    logic [7:0]    r_b;
    logic          r_last;
    logic [31:0]   r_cp;
    logic [31:0]   r_ecp;
    logic [LW-1:0] r_len;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_store [NAME_MAX_LEN];
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_orl;
    logic          r_ote;

    logic [3:0]    hv;
    logic          tbl_hit;
    logic [31:0]   tbl_cp;
    logic [1:0]    nbm1;
    logic [7:0]    utf8_byte;
    logic [7:0]    raw_byte;
    logic [CW-1:0] cnt_m1;
    logic [7:0]    out_next;
    logic          m;

    // input byte classes and held state flags
    always_comb begin
        o_stat.in_digit = (i_byte >= "0") && (i_byte <= "9");
        o_stat.in_alpha = ((i_byte >= "A") && (i_byte <= "Z"))
                       || ((i_byte >= "a") && (i_byte <= "z"));
        o_stat.in_hex   = o_stat.in_digit
                       || ((i_byte >= "a") && (i_byte <= "f"))
                       || ((i_byte >= "A") && (i_byte <= "F"));
        o_stat.in_amp   = (i_byte == CH_AMP);
        o_stat.in_hash  = (i_byte == CH_HASH);
        o_stat.in_x     = (i_byte == "x") || (i_byte == "X");
        o_stat.in_semi  = (i_byte == CH_SEMI);

        o_stat.held_amp     = (r_b == CH_AMP);
        o_stat.held_last    = r_last;
        o_stat.len_full     = (r_len == LW'(NAME_MAX_LEN));
        o_stat.tbl_hit      = tbl_hit;
        o_stat.utf8_end     = (r_cnt == CW'(nbm1));
        o_stat.raw_at_len   = (r_cnt == CW'(r_len));
        o_stat.raw_past_len = (r_cnt == (CW'(r_len) + CW'(1)));
        o_stat.slot_free    = !r_ov || i_out_ready;
    end

    assign hv = o_stat.in_digit ? i_byte[3:0] : (i_byte[3:0] + 4'd9);

    // named reference lookup over the first letters of the buffer
    always_comb begin
        tbl_hit = 1'b0;
        tbl_cp  = '0;
        for (int i = 0; i < NAME_TBL_SIZE; i++) begin
            m = (r_len == LW'(NAME_LEN[i]));
            for (int j = 0; j < NAME_TBL_CHARS; j++) begin
                if ((3'(j) < NAME_LEN[i]) && (r_store[j] != NAME_TXT[i][47 - 8*j -: 8])) begin
                    m = 1'b0;
                end
            end
            if (m && !tbl_hit) begin
                tbl_hit = 1'b1;
                tbl_cp  = NAME_CP[i];
            end
        end
    end

    // UTF-8 length minus one and the byte at r_cnt
    always_comb begin
        if (r_ecp < 32'h80) begin
            nbm1 = 2'd0;
        end else if (r_ecp < 32'h800) begin
            nbm1 = 2'd1;
        end else if (r_ecp < 32'h10000) begin
            nbm1 = 2'd2;
        end else begin
            nbm1 = 2'd3;
        end
        utf8_byte = r_ecp[7:0];
        case ({nbm1, r_cnt[1:0]})
            4'b01_00: utf8_byte = {3'b110, r_ecp[10:6]};
            4'b01_01: utf8_byte = {2'b10, r_ecp[5:0]};
            4'b10_00: utf8_byte = {4'b1110, r_ecp[15:12]};
            4'b10_01: utf8_byte = {2'b10, r_ecp[11:6]};
            4'b10_10: utf8_byte = {2'b10, r_ecp[5:0]};
            4'b11_00: utf8_byte = 8'hF0 | r_ecp[25:18];
            4'b11_01: utf8_byte = {2'b10, r_ecp[17:12]};
            4'b11_10: utf8_byte = {2'b10, r_ecp[11:6]};
            4'b11_11: utf8_byte = {2'b10, r_ecp[5:0]};
            default:  utf8_byte = r_ecp[7:0];
        endcase
    end

    assign cnt_m1 = r_cnt - CW'(1);

    always_comb begin
        if (r_cnt == '0) begin
            raw_byte = CH_AMP;
        end else if (r_cnt <= CW'(r_len)) begin
            raw_byte = r_store[cnt_m1[IW-1:0]];
        end else begin
            raw_byte = CH_SEMI;
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            OSEL_IN:   out_next = i_byte;
            OSEL_HELD: out_next = r_b;
            OSEL_UTF8: out_next = utf8_byte;
            OSEL_RAW:  out_next = raw_byte;
            default:   out_next = i_byte;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_b    <= i_byte;
            r_last <= i_last;
        end
        if (i_cmd.name_push) begin
            r_store[r_len[IW-1:0]] <= i_byte;
        end
        case (i_cmd.ecp_load)
            ECP_ACC:   r_ecp <= r_cp;
            ECP_TABLE: r_ecp <= tbl_cp;
            default:   r_ecp <= r_ecp;
        endcase
        if (i_cmd.out_load) begin
            r_ob  <= out_next;
            r_orl <= i_cmd.out_final;
            r_ote <= i_cmd.out_final
                  && ((i_cmd.out_sel == OSEL_IN) ? i_last : r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp  <= '0;
            r_len <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.clear_ref) begin
                r_cp  <= '0;
                r_len <= '0;
            end else begin
                case (i_cmd.cp_op)
                    CP_DEC:  r_cp <= (r_cp << 3) + (r_cp << 1) + 32'(i_byte[3:0]);
                    CP_HEX:  r_cp <= (r_cp << 4) + 32'(hv);
                    default: r_cp <= r_cp;
                endcase
                if (i_cmd.name_push) begin
                    r_len <= r_len + LW'(1);
                end
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_last  = r_orl;
    assign o_text_end  = r_ote;

endmodule

### rtl/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl: decoder controller
// Tracks the reference parser mode and sequences lookup, UTF-8 emission,
// raw replay and the trailing byte of a closed reference.
// ----------------------------------------------------------------------------
module hed_ctrl
    import hed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_last,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIN   = 5'b00010,
        S_CP    = 5'b00100,
        S_RAW   = 5'b01000,
        S_PLAIN = 5'b10000
    } t_state;

    typedef enum logic [5:0] {
        M_NORMAL = 6'b000001,
        M_AMP    = 6'b000010,
        M_HASH   = 6'b000100,
        M_DEC    = 6'b001000,
        M_HEX    = 6'b010000,
        M_NAME   = 6'b100000
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_semi, n_semi;
    logic   r_plain, n_plain;
    logic   r_flush, n_flush;

    logic is_name, is_num, more, seg_done;

    assign is_name = (r_mode == M_AMP) || (r_mode == M_NAME);
    assign is_num  = (r_mode == M_HASH) || (r_mode == M_DEC) || (r_mode == M_HEX);
    // further bytes follow the current reference in this word
    assign more    = !r_flush && r_plain && (!i_stat.held_amp || i_stat.held_last);
    assign o_ready = (r_state == S_IDLE) && i_stat.slot_free;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_mode   = r_mode;
        n_semi   = r_semi;
        n_plain  = r_plain;
        n_flush  = r_flush;
        seg_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.capture = 1'b1;
                    n_semi  = 1'b0;
                    n_plain = 1'b0;
                    n_flush = 1'b0;
                    if ((r_mode == M_AMP) && i_stat.in_hash) begin
                        n_mode = M_HASH;
                    end else if (is_name) begin
                        n_mode = M_NAME;
                        if (i_stat.in_alpha && !i_stat.len_full) begin
                            o_cmd.name_push = 1'b1;
                        end else begin
                            n_semi  = i_stat.in_semi;
                            n_plain = !i_stat.in_semi;
                            n_state = S_FIN;
                        end
                    end else if ((r_mode == M_HASH) && i_stat.in_x) begin
                        n_mode = M_HEX;
                    end else if (((r_mode == M_HASH) || (r_mode == M_DEC))
                                 && i_stat.in_digit) begin
                        n_mode = M_DEC;
                        o_cmd.cp_op = CP_DEC;
                    end else if ((r_mode == M_HEX) && i_stat.in_hex) begin
                        o_cmd.cp_op = CP_HEX;
                    end else if (is_num) begin
                        n_semi  = i_stat.in_semi;
                        n_plain = !i_stat.in_semi;
                        n_state = S_FIN;
                    end else if (i_stat.in_amp) begin
                        n_mode = M_AMP;
                        o_cmd.clear_ref = 1'b1;
                    end else begin
                        n_mode = M_NORMAL;
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_sel   = OSEL_IN;
                        o_cmd.out_final = 1'b1;
                    end
                    // flush a reference still open at the last byte
                    if ((n_state == S_IDLE) && i_last && (n_mode != M_NORMAL)) begin
                        n_flush = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.cnt_clr = 1'b1;
                if (is_name) begin
                    o_cmd.ecp_load = ECP_TABLE;
                    n_state = i_stat.tbl_hit ? S_CP : S_RAW;
                end else begin
                    o_cmd.ecp_load = ECP_ACC;
                    n_state = S_CP;
                end
            end
            S_CP: begin
                if (i_stat.slot_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OSEL_UTF8;
                    o_cmd.cnt_inc   = 1'b1;
                    o_cmd.out_final = i_stat.utf8_end && !more;
                    seg_done        = i_stat.utf8_end;
                end
            end
            S_RAW: begin
                if (i_stat.slot_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OSEL_RAW;
                    o_cmd.cnt_inc   = 1'b1;
                    seg_done        = r_semi ? i_stat.raw_past_len : i_stat.raw_at_len;
                    o_cmd.out_final = seg_done && !more;
                end
            end
            S_PLAIN: begin
                if (i_stat.held_amp) begin
                    n_mode = M_AMP;
                    if (i_stat.held_last) begin
                        n_flush = 1'b1;
                        n_semi  = 1'b0;
                        n_plain = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.slot_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OSEL_HELD;
                    o_cmd.out_final = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // close the reference and go on with the byte that ended it, unless that byte was a ';'
        if (seg_done) begin
            o_cmd.clear_ref = 1'b1;
            n_mode  = M_NORMAL;
            n_state = (!r_flush && r_plain) ? S_PLAIN : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_NORMAL;
            r_semi  <= 1'b0;
            r_plain <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_semi  <= n_semi;
            r_plain <= n_plain;
            r_flush <= n_flush;
        end
    end

endmodule

### rtl/html_entity_decoder_utf8.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_utf8: streaming HTML character reference decoder
// Decodes numeric and named references in a byte stream into UTF-8.
// ----------------------------------------------------------------------------
// A text byte that passes through, or that only extends an open reference,
// needs no further sequencing. A byte that closes a reference, or a last byte
// that leaves one open, is followed by the name lookup or code point load,
// then the output bytes (one to four UTF-8 bytes, or '&', up to NAME_MAX_LEN
// letters and ';' for an unknown name), then the closing byte itself when it
// is ordinary text; an '&' there that is also the last byte adds another
// lookup and its one-byte replay. The single output register takes one word
// per cycle when the output is not stalled; no new input byte is taken until
// the sequencer is idle again, and a stalled output holds the input.
module html_entity_decoder_utf8
    import hed_pkg::*;
#(
    parameter int NAME_MAX_LEN = 31
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hed_in_if.sink    i_in,
    hed_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ready;

    hed_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_last  (i_in.in_last),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    hed_dp #(
        .NAME_MAX_LEN (NAME_MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.in_last),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_run_last  (o_out.run_last),
        .o_text_end  (o_out.text_end)
    );

    assign i_in.ready = ready;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: character reference decoder testbench
// Feeds text with numeric, named, unknown and broken references through the
// decoder. An internal predictor computes the UTF-8 output of every accepted
// byte, and a scoreboard compares each output word with it in order.
// ----------------------------------------------------------------------------
module tb_top
    import hed_pkg::*;
();

    localparam int NAME_LIMIT = 31;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_MISMATCH_PRINT = 10;

    typedef enum logic [2:0] {
        ST_TEXT, ST_AMP, ST_HASH, ST_DEC, ST_HEX, ST_NAME
    } t_parse_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    logic i_clk;
    logic i_rst_n;

    hed_in_if  in_ch ();
    hed_out_if out_ch ();

    html_entity_decoder_utf8 #(.NAME_MAX_LEN(NAME_LIMIT)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // predictor state
    t_parse_state pstate;
    logic [31:0]  acc_cp;
    logic [7:0]   name_buf [NAME_LIMIT];
    int           name_cnt;

    t_out_word  expected_words [$];
    t_out_word  step_words [$];
    t_in_word   send_queue [$];
    int         mismatches;
    int         words_checked;
    int         bytes_sent;
    int         idle_cycles;
    bit         hold_receiver;
    bit         stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (is_dec(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    task automatic emit(logic [7:0] b);
        t_out_word w;
        w.out_byte = b;
        w.run_last = 1'b0;
        w.text_end = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic emit_utf8(logic [31:0] cp);
        if (cp < 32'h80) begin
            emit(cp[7:0]);
        end else if (cp < 32'h800) begin
            emit(8'hC0 | cp[10:6]);
            emit(8'h80 | cp[5:0]);
        end else if (cp < 32'h10000) begin
            emit(8'hE0 | cp[15:12]);
            emit(8'h80 | cp[11:6]);
            emit(8'h80 | cp[5:0]);
        end else begin
            emit(8'hF0 | cp[25:18]);
            emit(8'h80 | cp[17:12]);
            emit(8'h80 | cp[11:6]);
            emit(8'h80 | cp[5:0]);
        end
    endtask

    function automatic logic [31:0] lookup_name();
        logic [47:0] txt;
        bit hit;
        for (int i = 0; i < NAME_TBL_SIZE; i++) begin
            if (int'(NAME_LEN[i]) == name_cnt) begin
                txt = NAME_TXT[i];
                hit = 1'b1;
                for (int k = 0; k < name_cnt; k++)
                    if (txt[47 - 8 * k -: 8] != name_buf[k]) hit = 1'b0;
                if (hit) return NAME_CP[i];
            end
        end
        return 32'd0;
    endfunction

    task automatic close_ref(bit semi);
        logic [31:0] cp;
        if (pstate == ST_AMP || pstate == ST_NAME) begin
            cp = lookup_name();
            if (cp != 0) begin
                emit_utf8(cp);
            end else begin
                emit(CH_AMP);
                for (int k = 0; k < name_cnt; k++) emit(name_buf[k]);
                if (semi) emit(CH_SEMI);
            end
        end else if (pstate != ST_TEXT) begin
            emit_utf8(acc_cp);
        end
        pstate = ST_TEXT;
        acc_cp = '0;
        name_cnt = 0;
    endtask

    task automatic text_byte(logic [7:0] b);
        if (b == CH_AMP) begin
            pstate = ST_AMP;
            acc_cp = '0;
            name_cnt = 0;
        end else begin
            emit(b);
        end
    endtask

    task automatic decode_byte(t_in_word w);
        logic [7:0] b;
        int hv;
        b = w.in_byte;
        hv = hex_digit(b);
        step_words.delete();
        if (pstate == ST_AMP && b == CH_HASH) begin
            pstate = ST_HASH;
        end else if (pstate == ST_AMP || pstate == ST_NAME) begin
            pstate = ST_NAME;
            if (is_letter(b) && name_cnt < NAME_LIMIT) begin
                name_buf[name_cnt] = b;
                name_cnt++;
            end else if (b == CH_SEMI) begin
                close_ref(1'b1);
            end else begin
                close_ref(1'b0);
                text_byte(b);
            end
        end else if (pstate == ST_HASH && (b == "x" || b == "X")) begin
            pstate = ST_HEX;
        end else if ((pstate == ST_HASH || pstate == ST_DEC) && is_dec(b)) begin
            pstate = ST_DEC;
            acc_cp = acc_cp * 10 + (b - "0");
        end else if (pstate == ST_HEX && hv >= 0) begin
            acc_cp = acc_cp * 16 + hv;
        end else if (pstate != ST_TEXT) begin
            if (b == CH_SEMI) begin
                close_ref(1'b1);
            end else begin
                close_ref(1'b0);
                text_byte(b);
            end
        end else begin
            text_byte(b);
        end
        if (w.in_last && pstate != ST_TEXT) close_ref(1'b0);
        if (step_words.size() > 0) begin
            step_words[$].run_last = 1'b1;
            step_words[$].text_end = w.in_last;
        end
        foreach (step_words[k]) expected_words.push_back(step_words[k]);
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic queue_str(string s, bit last_at_end);
        t_in_word w;
        for (int k = 0; k < s.len(); k++) begin
            w.in_byte = s[k];
            w.in_last = last_at_end && (k == s.len() - 1);
            send_queue.push_back(w);
        end
    endtask

    function automatic string random_name();
        string s;
        int n;
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(0, NAME_TBL_SIZE - 1);
                s = "";
                for (int k = 0; k < int'(NAME_LEN[n]); k++)
                    s = {s, string'(NAME_TXT[n][47 - 8 * k -: 8])};
            end
            default: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 34)
                                                : $urandom_range(0, 6);
                s = "";
                for (int k = 0; k < n; k++)
                    s = {s, string'($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                         : 8'($urandom_range("A", "Z")))};
            end
        endcase
        return s;
    endfunction

    function automatic string random_ref();
        string s;
        string hex_chars;
        int n;
        hex_chars = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 5))
            0, 1: s = {"&", random_name()};
            2: begin
                s = "&#";
                n = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 12 : 6);
                for (int k = 0; k < n; k++)
                    s = {s, string'(8'($urandom_range("0", "9")))};
            end
            3: begin
                s = $urandom_range(0, 1) ? "&#x" : "&#X";
                n = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 10 : 6);
                for (int k = 0; k < n; k++)
                    s = {s, string'(hex_chars[$urandom_range(0, 21)])};
            end
            4: s = "&";
            default: s = {"&", string'(8'($urandom_range(0, 255)))};
        endcase
        // usual terminator is ';', otherwise whatever text follows closes it
        if ($urandom_range(0, 2) != 0) s = {s, ";"};
        return s;
    endfunction

    task automatic queue_random(int target);
        t_in_word w;
        int start;
        start = send_queue.size();
        while (send_queue.size() - start < target) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_str(random_ref(), 1'b0);
            end else begin
                w.in_byte = 8'($urandom_range(0, 255));
                w.in_last = 1'b0;
                send_queue.push_back(w);
            end
            if ($urandom_range(0, 9) == 0) send_queue[$].in_last = 1'b1;
        end
    endtask

    // directed rows; where the output is obvious it is given and also checked
    typedef struct {
        string txt;
        string want;
    } t_row;

    t_row directed_rows [] = '{
        '{"A", "A"},
        '{"&amp;", "&"},
        '{"&lt", ""},
        '{"&#65;", "A"},
        '{"&#x41;", "A"},
        '{"&#X7e;", "~"},
        '{"&#;", ""},
        '{"&#x;", ""},
        '{"&#169;", ""},
        '{"&#x20AC;", ""},
        '{"&#x10FFFF;", ""},
        '{"&#xFFFFFFFF;", ""},
        '{"&#4294967297;", ""},
        '{"&foo;", "&foo;"},
        '{"&;", "&;"},
        '{"& ", "& "},
        '{"&&amp", ""},
        '{"&nbspX", ""},
        '{"&trade;", ""},
        '{"&ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefg;", ""},
        '{"\xff\x00", ""}
    };

    int pass_mark;

    initial begin
        string full_str;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        i_rst_n = 1'b0;
        pstate = ST_TEXT;
        acc_cp = '0;
        name_cnt = 0;
        mismatches = 0;
        words_checked = 0;
        bytes_sent = 0;
        hold_receiver = 1'b0;
        stimulus_done = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            queue_str(directed_rows[r].txt, 1'b1);
            if (directed_rows[r].want != "") begin
                // cross-check the predictor against the obvious answer
                pass_mark = expected_words.size();
                foreach (send_queue[k]) decode_byte(send_queue[k]);
                full_str = "";
                for (int k = pass_mark; k < expected_words.size(); k++)
                    full_str = {full_str, string'(expected_words[k].out_byte)};
                if (full_str != directed_rows[r].want) begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_PRINT)
                        $display("predictor row %0d: got \"%s\" want \"%s\"", r, full_str,
                                 directed_rows[r].want);
                end
                while (expected_words.size() > pass_mark) void'(expected_words.pop_back());
                pstate = ST_TEXT;
                acc_cp = '0;
                name_cnt = 0;
            end
            send_all();
        end

        // fill the block while the receiver holds off
        hold_receiver = 1'b1;
        queue_random(40);
        send_all();
        wait (!hold_receiver);
        @(negedge i_clk);

        queue_random(80);
        send_all();
        wait (expected_words.size() == 0);
        @(negedge i_clk);
        queue_random(80);
        send_queue[$].in_last = 1'b1;
        send_all();
        stimulus_done = 1'b1;
    end

    task automatic send_all();
        int gap;
        while (send_queue.size() > 0) begin
            in_ch.valid   <= 1'b1;
            in_ch.in_byte <= send_queue[0].in_byte;
            in_ch.in_last <= send_queue[0].in_last;
            do @(posedge i_clk); while (!in_ch.ready);
            decode_byte(send_queue.pop_front());
            bytes_sent++;
            @(negedge i_clk);
            gap = 0;
            if (send_queue.size() == 0)
                gap = 1;
            else if ($urandom_range(0, 2) == 0 && !hold_receiver)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin
        int stretch;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_receiver = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
                repeat (stretch) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // scoreboard
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.out_byte = out_ch.out_byte;
            got.run_last = out_ch.run_last;
            got.text_end = out_ch.text_end;
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH_PRINT)
                    $display("unexpected output word %h/%b/%b", got.out_byte,
                             got.run_last, got.text_end);
            end else begin
                want = expected_words.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_PRINT)
                        $display("word %0d: expected %h/%b/%b got %h/%b/%b",
                                 words_checked, want.out_byte, want.run_last,
                                 want.text_end, got.out_byte, got.run_last,
                                 got.text_end);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || hold_receiver)
                idle_cycles = 0;
            else if (!(stimulus_done && expected_words.size() == 0))
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress, %0d words outstanding",
                         expected_words.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        wait (expected_words.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d text bytes, checked %0d decoded words", bytes_sent,
                 words_checked);
        $display("covering numeric, named, unknown and truncated references.");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/hed_pkg.sv
rtl/hed_if.sv
rtl/hed_dp.sv
rtl/hed_ctrl.sv
rtl/html_entity_decoder_utf8.sv
tb/tb_top.sv
